### sv/btrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btrp_pkg;

  // widths fixed by the register map and the stamp format
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TICK_W    = 16;

  // store depth default
  localparam int DEPTH_DEFAULT = 256;

  // last blink count before a transition mode ends
  localparam int BLINK_LAST = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TICKS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYBACK_LEAD = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] MAX_TICKS_RST     = 16'd16000;
  localparam logic [CFG_W-1:0] IDLE_LIMIT_RST    = 16'd500;
  localparam logic [CFG_W-1:0] BLINK_PERIOD_RST  = 16'd30;
  localparam logic [CFG_W-1:0] PLAYBACK_LEAD_RST = 16'd100;

  typedef struct packed {
    logic [CFG_W-1:0] max_ticks;
    logic [CFG_W-1:0] idle_limit;
    logic [CFG_W-1:0] blink_period;
    logic [CFG_W-1:0] playback_lead;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_RECORD    = 2'd0,
    MODE_TO_PLAY   = 2'd1,
    MODE_PLAY      = 2'd2,
    MODE_TO_RECORD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_EXEC
  } seq_state_t;

endpackage

`default_nettype wire

### sv/btrp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// tick request: one button sample
interface btrp_in_if;
  logic valid;
  logic ready;
  logic button_released;

  modport source (output valid, output button_released, input ready);
  modport sink (input valid, input button_released, output ready);
endinterface

// indicator result after each tick
interface btrp_out_if;
  logic       valid;
  logic       ready;
  logic       red_led;
  logic       grn_led;
  logic [1:0] mode_now;

  modport source (output valid, output red_led, output grn_led, output mode_now,
                  input ready);
  modport sink (input valid, input red_led, input grn_led, input mode_now,
                output ready);
endinterface

`default_nettype wire

### sv/btrp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module btrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/btrp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module btrp_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [btrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [btrp_pkg::CFG_W-1:0]       cfg_wdata,
  output btrp_pkg::cfg_t                        cfg
);

  // register file with decode of the write index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_ticks     <= btrp_pkg::MAX_TICKS_RST;
      cfg.idle_limit    <= btrp_pkg::IDLE_LIMIT_RST;
      cfg.blink_period  <= btrp_pkg::BLINK_PERIOD_RST;
      cfg.playback_lead <= btrp_pkg::PLAYBACK_LEAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btrp_pkg::CFG_MAX_TICKS:     cfg.max_ticks     <= cfg_wdata;
        btrp_pkg::CFG_IDLE_LIMIT:    cfg.idle_limit    <= cfg_wdata;
        btrp_pkg::CFG_BLINK_PERIOD:  cfg.blink_period  <= cfg_wdata;
        btrp_pkg::CFG_PLAYBACK_LEAD: cfg.playback_lead <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/btrp_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module btrp_seq #(
  parameter int DEPTH = btrp_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire btrp_pkg::cfg_t              cfg,
  btrp_in_if.sink                          tick_in,
  btrp_out_if.source                       led_out,
  output logic                             mem_we,
  output logic [$clog2(DEPTH)-1:0]         mem_waddr,
  output logic [btrp_pkg::TICK_W-1:0]      mem_wdata,
  output logic                             mem_re,
  output logic [$clog2(DEPTH)-1:0]         mem_raddr,
  input  wire logic [btrp_pkg::TICK_W-1:0] mem_rdata
);

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (CNT_W > 3) ? CNT_W : 3;
  localparam int TICK_W  = btrp_pkg::TICK_W;

  btrp_pkg::seq_state_t state, state_next;
  btrp_pkg::mode_t      mode, mode_next;
  btrp_pkg::mode_t      leave_mode;

  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [IDX_W-1:0]  event_index, event_index_next;
  logic              last_released, last_released_next;
  logic              red_state, red_state_next;
  logic              green_state, green_state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic              btn;
  logic              out_valid;

  logic              accept;
  logic              fire;
  logic              leave;
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] idle_gap;
  logic              ei_full;
  logic              ei_zero;
  logic [ADDR_W-1:0] ei_addr;
  logic              clr_last;

  assign accept   = tick_in.valid && tick_in.ready;
  assign fire     = (state == btrp_pkg::SEQ_EXEC) && (!out_valid || led_out.ready);
  assign tick_inc = tick_count + TICK_W'(1);
  assign idle_gap = tick_count - mem_rdata;
  assign ei_full  = (event_index == IDX_W'(DEPTH));
  assign ei_zero  = (event_index == '0);
  assign ei_addr  = event_index[ADDR_W-1:0];
  assign clr_last = (clr_addr == ADDR_W'(DEPTH - 1));

  assign tick_in.ready     = (state == btrp_pkg::SEQ_IDLE);
  assign led_out.valid     = out_valid;
  assign led_out.red_led   = red_state;
  assign led_out.grn_led   = green_state;
  assign led_out.mode_now  = mode;

  // stamp read issued with the request: previous stamp in record, current in playback
  assign mem_re = accept;
  always_comb begin
    unique case (mode) inside
      btrp_pkg::MODE_RECORD:                           mem_raddr = ei_addr - ADDR_W'(1);
      btrp_pkg::MODE_PLAY:                             mem_raddr = ei_addr;
      btrp_pkg::MODE_TO_PLAY, btrp_pkg::MODE_TO_RECORD: mem_raddr = '0;
      default:                                         mem_raddr = '0;
    endcase
  end

  // state register and tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= btrp_pkg::SEQ_CLEAR;
      mode          <= btrp_pkg::MODE_RECORD;
      tick_count    <= '0;
      event_index   <= '0;
      last_released <= 1'b1;
      red_state     <= 1'b1;
      green_state   <= 1'b0;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      mode          <= mode_next;
      tick_count    <= tick_count_next;
      event_index   <= event_index_next;
      last_released <= last_released_next;
      red_state     <= red_state_next;
      green_state   <= green_state_next;
      if (state == btrp_pkg::SEQ_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + ADDR_W'(1);
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (led_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // latched button level of the request
  always_ff @(posedge clk) begin
    if (accept) begin
      btn <= tick_in.button_released;
    end
  end

  // next state, tick update and stamp write-back
  always_comb begin
    state_next         = state;
    mode_next          = mode;
    tick_count_next    = tick_count;
    event_index_next   = event_index;
    last_released_next = last_released;
    red_state_next     = red_state;
    green_state_next   = green_state;
    mem_we             = 1'b0;
    mem_waddr          = clr_addr;
    mem_wdata          = '0;
    leave              = 1'b0;
    leave_mode         = btrp_pkg::MODE_TO_PLAY;

    unique case (state)
      btrp_pkg::SEQ_CLEAR: begin
        mem_we = 1'b1;
        if (clr_last) begin
          state_next = btrp_pkg::SEQ_IDLE;
        end
      end
      btrp_pkg::SEQ_IDLE: begin
        if (accept) begin
          state_next = btrp_pkg::SEQ_EXEC;
        end
      end
      btrp_pkg::SEQ_EXEC: begin
        if (fire) begin
          state_next = btrp_pkg::SEQ_IDLE;
          unique case (mode) inside
            btrp_pkg::MODE_RECORD: begin
              leave_mode = btrp_pkg::MODE_TO_PLAY;
              if (ei_full) begin
                leave = 1'b1;
              end else if (tick_count == cfg.max_ticks) begin
                // held press at the time limit leaves a final stamp
                if (!btn) begin
                  mem_we    = 1'b1;
                  mem_waddr = ei_addr;
                  mem_wdata = tick_count;
                end
                leave = 1'b1;
              end else if (last_released && !ei_zero && (idle_gap > cfg.idle_limit)) begin
                leave = 1'b1;
              end else begin
                tick_count_next = tick_inc;
                if (btn != last_released) begin
                  mem_we           = 1'b1;
                  mem_waddr        = ei_addr;
                  mem_wdata        = tick_inc;
                  event_index_next = event_index + IDX_W'(1);
                end
              end
              last_released_next = btn;
            end
            btrp_pkg::MODE_PLAY: begin
              leave_mode = btrp_pkg::MODE_TO_RECORD;
              if (ei_full) begin
                leave = 1'b1;
              end else if ((mem_rdata == '0) && !ei_zero) begin
                leave = 1'b1;
              end else if (tick_count == cfg.max_ticks) begin
                leave = 1'b1;
              end else begin
                tick_count_next = tick_inc;
                if (tick_inc == mem_rdata) begin
                  green_state_next = !green_state;
                  event_index_next = event_index + IDX_W'(1);
                end
              end
            end
            btrp_pkg::MODE_TO_PLAY, btrp_pkg::MODE_TO_RECORD: begin
              if (event_index > IDX_W'(btrp_pkg::BLINK_LAST)) begin
                tick_count_next  = '0;
                event_index_next = '0;
                red_state_next   = 1'b0;
                green_state_next = 1'b0;
                if (mode == btrp_pkg::MODE_TO_RECORD) begin
                  // back to record: red on, then sweep the store clear
                  mode_next      = btrp_pkg::MODE_RECORD;
                  red_state_next = 1'b1;
                  state_next     = btrp_pkg::SEQ_CLEAR;
                end else begin
                  mode_next = btrp_pkg::MODE_PLAY;
                  // early start when the first stamp is far out
                  if (mem_rdata > cfg.idle_limit) begin
                    tick_count_next = mem_rdata - cfg.playback_lead;
                  end
                end
              end else if (tick_count == cfg.blink_period) begin
                tick_count_next  = TICK_W'(1);
                red_state_next   = !red_state;
                event_index_next = event_index + IDX_W'(1);
              end else begin
                tick_count_next = tick_inc;
              end
            end
            default: ;
          endcase

          // common mode entry
          if (leave) begin
            mode_next        = leave_mode;
            tick_count_next  = '0;
            event_index_next = '0;
            red_state_next   = 1'b0;
            green_state_next = 1'b0;
          end
          // green follows the button in record, also on the leaving tick
          if (mode == btrp_pkg::MODE_RECORD) begin
            green_state_next = !btn;
          end
        end
      end
      default: state_next = btrp_pkg::SEQ_IDLE;
    endcase
  end

  // red stays lit through all of record mode
  assert property (@(posedge clk) disable iff (rst)
    (mode == btrp_pkg::MODE_RECORD) |-> red_state)
    else $error("red off in record mode");

  // green is dark while blinking back to record
  assert property (@(posedge clk) disable iff (rst)
    (mode == btrp_pkg::MODE_TO_RECORD) |-> !green_state)
    else $error("green on during transition to record");

  // a result appears only after an update step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == btrp_pkg::SEQ_EXEC))
    else $error("result without update");

  // no stamp index beyond the store in record and playback
  assert property (@(posedge clk) disable iff (rst)
    (mode == btrp_pkg::MODE_RECORD || mode == btrp_pkg::MODE_PLAY)
      |-> (event_index <= IDX_W'(DEPTH)))
    else $error("event index past store");

endmodule

`default_nettype wire

### sv/button_timing_record_playback_core.sv
// Button timing recorder with playback. Each request is one timer tick with the
// button level; each request yields exactly one result with the red and green
// indicator levels and the mode after that tick. Edge stamps live in a DEPTH x 16
// single-port-read memory. A request issues its stamp read when accepted, then is
// updated with write-back once the output stage is free, and the next request is
// accepted the cycle after the update while the result waits in the output stage.
// After reset and on every return to record mode the store is cleared one entry
// per cycle and no request is accepted; register writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module button_timing_record_playback_core #(
  parameter int DEPTH = btrp_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [btrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [btrp_pkg::CFG_W-1:0]     cfg_wdata,
  btrp_in_if.sink                             tick_in,
  btrp_out_if.source                          led_out
);

  localparam int ADDR_W = $clog2(DEPTH);

  btrp_pkg::cfg_t                cfg;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_waddr;
  logic [btrp_pkg::TICK_W-1:0]   mem_wdata;
  logic                          mem_re;
  logic [ADDR_W-1:0]             mem_raddr;
  logic [btrp_pkg::TICK_W-1:0]   mem_rdata;

  // configuration registers
  btrp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stamp store
  btrp_ram #(
    .WIDTH (btrp_pkg::TICK_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // mode sequencer and tick datapath
  btrp_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tick_in   (tick_in),
    .led_out   (led_out),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire
